// ----- src/mcfb_pkg.sv -----
// Shared types and constants for the motor command frame builder.
// No dependencies; every other file refers to it by scoped names.
package mcfb_pkg;

   // command kinds on the request channel
   localparam logic [2:0] KIND_OFF     = 3'd0;
   localparam logic [2:0] KIND_STOP    = 3'd1;
   localparam logic [2:0] KIND_RESTORE = 3'd2;
   localparam logic [2:0] KIND_SPEED   = 3'd3;
   localparam logic [2:0] KIND_ANGLE   = 3'd4;

   // frame constants
   localparam logic [7:0] FRAME_HEADER   = 8'h3E;
   localparam logic [7:0] OPCODE_OFF     = 8'h80;
   localparam logic [7:0] OPCODE_STOP    = 8'h81;
   localparam logic [7:0] OPCODE_RESTORE = 8'h88;
   localparam logic [7:0] OPCODE_SPEED   = 8'hA2;
   localparam logic [7:0] OPCODE_ANGLE   = 8'hA3;
   localparam logic [7:0] DLEN_NONE      = 8'h00;
   localparam logic [7:0] DLEN_SPEED     = 8'h04;
   localparam logic [7:0] DLEN_ANGLE     = 8'h08;
   localparam logic [31:0] SCALE_FACTOR  = 32'd100;
   localparam logic [7:0] MOTOR_ID_RESET = 8'd1;

   // byte positions within a frame
   localparam logic [3:0] POS_HEADER     = 4'd0;
   localparam logic [3:0] POS_OPCODE     = 4'd1;
   localparam logic [3:0] POS_ID         = 4'd2;
   localparam logic [3:0] POS_DLEN       = 4'd3;
   localparam logic [3:0] POS_HSUM       = 4'd4;
   localparam logic [3:0] POS_DATA_FIRST = 4'd5;
   localparam logic [3:0] POS_DATA_LOW_LAST = 4'd8;
   localparam logic [3:0] LAST_SHORT     = 4'd4;
   localparam logic [3:0] LAST_SPEED     = 4'd9;
   localparam logic [3:0] LAST_ANGLE     = 4'd13;

   // one classified command, as queued between front and back
   typedef struct packed {
      logic [7:0]  opcode;
      logic [7:0]  motor_id;
      logic [7:0]  dlen;
      logic [7:0]  hsum;
      logic [3:0]  last_idx;
      logic [31:0] scaled;
   } cmd_type;

endpackage

// ----- src/motor_command_frame_builder.sv -----
// Motor command frame builder: top level joining front end, queue and
// serialiser. Depends on mcfb_pkg, mcfb_front, mcfb_queue and mcfb_back.
//
// Use: present a command on req_kind/req_value with req_valid; it is taken
// at a clock edge where req_stall is low. Kinds 5 to 7 are taken and
// dropped without any response. Each valid command yields its frame on the
// rsp_ channel, one byte per transfer taken, rsp_last_byte marking the
// final byte: 5 bytes for off, stop and restore, 10 for speed, 14 for
// multi-turn angle. csr_write_enable loads the motor id; write it only
// while idle, as the block itself does not enforce this. The first byte
// passes the input stage, whose value feeds the scaling multiply, then the
// queue, the serialiser load and the output register. The serialiser then
// sends one byte per cycle while rsp_stall is low, and it loads the next
// queued command only after emitting the last byte of a frame; it sets the
// pace of the response channel. Up to QUEUE_DEPTH commands plus one in the
// input stage wait behind a busy serialiser before req_stall rises. While
// rsp_stall is high a valid byte holds and the serialiser waits. Reset
// clears all queued work, drops rsp_valid and sets the motor id to 1.
module motor_command_frame_builder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_kind,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last_byte,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data
);

   mcfb_pkg::cmd_type push_entry;
   mcfb_pkg::cmd_type head_entry;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   mcfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   mcfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_entry (head_entry)
   );

   mcfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (head_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

// ----- src/mcfb_front.sv -----
// Front end: takes requests, holds the motor id register, drops unknown
// kinds, scales the value and builds a queue entry. Uses mcfb_pkg.
module mcfb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_kind,
   input  logic signed [31:0]   req_value,
   input  logic                 csr_write_enable,
   input  logic [7:0]           csr_write_data,
   input  logic                 q_full,
   output logic                 q_push,
   output mcfb_pkg::cmd_type    q_entry
);

   logic        stage_valid_ff, stage_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] value_ff, value_in;
   logic [7:0]  motor_id_ff;
   logic        accept;
   logic        known;
   logic [7:0]  opcode;
   logic [7:0]  dlen;
   logic [3:0]  last_idx;
   logic [31:0] product;

   assign req_stall = stage_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign known     = (req_kind <= mcfb_pkg::KIND_ANGLE);
   assign q_push    = stage_valid_ff && !q_full;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      kind_in        = kind_ff;
      value_in       = value_ff;
      if (!req_stall) begin
         // drop unknown kinds here; they never reach the queue
         stage_valid_in = accept && known;
         kind_in        = req_kind;
         value_in       = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         motor_id_ff    <= mcfb_pkg::MOTOR_ID_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_write_enable) begin
            motor_id_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
   end

   always_comb begin
      unique case (kind_ff)
         mcfb_pkg::KIND_OFF: begin
            opcode = mcfb_pkg::OPCODE_OFF;
            dlen = mcfb_pkg::DLEN_NONE;
            last_idx = mcfb_pkg::LAST_SHORT;
         end
         mcfb_pkg::KIND_STOP: begin
            opcode = mcfb_pkg::OPCODE_STOP;
            dlen = mcfb_pkg::DLEN_NONE;
            last_idx = mcfb_pkg::LAST_SHORT;
         end
         mcfb_pkg::KIND_RESTORE: begin
            opcode = mcfb_pkg::OPCODE_RESTORE;
            dlen = mcfb_pkg::DLEN_NONE;
            last_idx = mcfb_pkg::LAST_SHORT;
         end
         mcfb_pkg::KIND_SPEED: begin
            opcode = mcfb_pkg::OPCODE_SPEED;
            dlen = mcfb_pkg::DLEN_SPEED;
            last_idx = mcfb_pkg::LAST_SPEED;
         end
         mcfb_pkg::KIND_ANGLE: begin
            opcode = mcfb_pkg::OPCODE_ANGLE;
            dlen = mcfb_pkg::DLEN_ANGLE;
            last_idx = mcfb_pkg::LAST_ANGLE;
         end
         default: begin
            opcode = mcfb_pkg::OPCODE_OFF;
            dlen = mcfb_pkg::DLEN_NONE;
            last_idx = mcfb_pkg::LAST_SHORT;
         end
      endcase
   end

   // wraps modulo 2^32; the queue entry registers it
   assign product = 32'(value_ff * mcfb_pkg::SCALE_FACTOR);

   always_comb begin
      q_entry.opcode   = opcode;
      q_entry.motor_id = motor_id_ff;
      q_entry.dlen     = dlen;
      q_entry.hsum     = 8'(mcfb_pkg::FRAME_HEADER + opcode + motor_id_ff + dlen);
      q_entry.last_idx = last_idx;
      q_entry.scaled   = (dlen == mcfb_pkg::DLEN_NONE) ? 32'd0 : product;
   end

endmodule

// ----- src/mcfb_queue.sv -----
// Short command queue between the front end and the serialiser.
// Holds mcfb_pkg::cmd_type entries; depth set by DEPTH (at least 2).
module mcfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mcfb_pkg::cmd_type    push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output mcfb_pkg::cmd_type    head_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   mcfb_pkg::cmd_type    entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/mcfb_back.sv -----
// Back end: takes one queued command at a time and serialises its frame,
// one byte per cycle unless stalled, into the response register. Uses mcfb_pkg.
module mcfb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  mcfb_pkg::cmd_type    q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_last_byte
);

   logic              busy_ff, busy_in;
   mcfb_pkg::cmd_type cur_ff, cur_in;
   logic [3:0]        idx_ff, idx_in;
   logic [7:0]        dsum_ff, dsum_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_free;
   logic              emit;
   logic              is_last;
   logic [3:0]        data_off;
   logic [7:0]        low_byte;
   logic [7:0]        ext_byte;
   logic [7:0]        next_byte;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign q_pop    = !busy_ff && !q_empty;
   assign is_last  = (idx_ff == cur_ff.last_idx);
   assign data_off = idx_ff - mcfb_pkg::POS_DATA_FIRST;
   assign ext_byte = {8{cur_ff.scaled[31]}};

   always_comb begin
      unique case (data_off[1:0])
         2'd0: low_byte = cur_ff.scaled[7:0];
         2'd1: low_byte = cur_ff.scaled[15:8];
         2'd2: low_byte = cur_ff.scaled[23:16];
         2'd3: low_byte = cur_ff.scaled[31:24];
         default: low_byte = cur_ff.scaled[7:0];
      endcase
   end

   always_comb begin
      priority if (idx_ff == mcfb_pkg::POS_HEADER) begin
         next_byte = mcfb_pkg::FRAME_HEADER;
      end else if (idx_ff == mcfb_pkg::POS_OPCODE) begin
         next_byte = cur_ff.opcode;
      end else if (idx_ff == mcfb_pkg::POS_ID) begin
         next_byte = cur_ff.motor_id;
      end else if (idx_ff == mcfb_pkg::POS_DLEN) begin
         next_byte = cur_ff.dlen;
      end else if (idx_ff == mcfb_pkg::POS_HSUM) begin
         next_byte = cur_ff.hsum;
      end else if (is_last) begin
         next_byte = dsum_ff;
      end else if (idx_ff <= mcfb_pkg::POS_DATA_LOW_LAST) begin
         next_byte = low_byte;
      end else begin
         next_byte = ext_byte;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      dsum_in      = dsum_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         cur_in  = q_head;
         idx_in  = mcfb_pkg::POS_HEADER;
         dsum_in = 8'd0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = next_byte;
         out_last_in  = is_last;
         idx_in       = idx_ff + 1'b1;
         // accumulate data bytes only
         if (idx_ff >= mcfb_pkg::POS_DATA_FIRST && !is_last) begin
            dsum_in = dsum_ff + next_byte;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      dsum_ff     <= dsum_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;

endmodule

// ----- src/mcfb_checker.sv -----
// Port-level checker for the motor command frame builder, with its bind.
// Depends on mcfb_pkg for the frame header value.
module mcfb_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [7:0]          rsp_frame_byte,
   input logic                rsp_last_byte
);

   logic       rsp_take;
   logic [3:0] pos_ff, pos_in;

   assign rsp_take = rsp_valid && !rsp_stall;

   // position of the current response byte within its frame
   always_comb begin
      pos_in = pos_ff;
      if (rsp_take) begin
         pos_in = rsp_last_byte ? 4'd0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_last_byte))
      else $error("stalled response changed");

   a_header_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == 4'd0 |-> rsp_frame_byte == mcfb_pkg::FRAME_HEADER)
      else $error("frame does not open with the header");

   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte |-> pos_ff == 4'd4 || pos_ff == 4'd9 || pos_ff == 4'd13)
      else $error("frame ends at an illegal length");

endmodule

bind motor_command_frame_builder mcfb_checker u_mcfb_checker (.*);

// ----- tb/sv/tb_motor_command_frame_builder.sv -----
`timescale 1ns / 100ps
// Self-checking bench for motor_command_frame_builder: a frame scoreboard
// predicts every byte of each command frame. Depends on mcfb_pkg and the RTL.

class frame_scoreboard;
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_entry_type;

   frame_entry_type pending_bytes[$];
   logic [7:0]   motor_id;
   logic [2:0]   last_kind;
   logic [31:0]  last_scaled;
   logic [7:0]   last_checksum;
   logic [3:0]   frame_length;
   int           error_count;

   function new();
      motor_id = mcfb_pkg::MOTOR_ID_RESET;
      last_kind = '0;
      last_scaled = '0;
      last_checksum = '0;
      frame_length = '0;
      error_count = 0;
   endfunction

   function void set_motor_id(logic [7:0] id);
      motor_id = id;
   endfunction

   function int pending();
      return pending_bytes.size();
   endfunction

   function void push_byte(logic [7:0] b, logic last);
      frame_entry_type e;
      e.frame_byte = b;
      e.last_byte = last;
      pending_bytes.insert(pending_bytes.size(), e);
      frame_length = frame_length + 4'd1;
   endfunction

   // Build the expected frame for one accepted request of a known kind.
   function void note_command(logic [2:0] kind, logic [31:0] value);
      logic [7:0]  opcode;
      logic [7:0]  dlen;
      logic [7:0]  hsum;
      logic [7:0]  dsum;
      logic [7:0]  ext;
      logic [7:0]  b;
      logic [31:0] scaled;
      case (kind)
         mcfb_pkg::KIND_OFF: begin
            opcode = mcfb_pkg::OPCODE_OFF;
            dlen = mcfb_pkg::DLEN_NONE;
         end
         mcfb_pkg::KIND_STOP: begin
            opcode = mcfb_pkg::OPCODE_STOP;
            dlen = mcfb_pkg::DLEN_NONE;
         end
         mcfb_pkg::KIND_RESTORE: begin
            opcode = mcfb_pkg::OPCODE_RESTORE;
            dlen = mcfb_pkg::DLEN_NONE;
         end
         mcfb_pkg::KIND_SPEED: begin
            opcode = mcfb_pkg::OPCODE_SPEED;
            dlen = mcfb_pkg::DLEN_SPEED;
         end
         mcfb_pkg::KIND_ANGLE: begin
            opcode = mcfb_pkg::OPCODE_ANGLE;
            dlen = mcfb_pkg::DLEN_ANGLE;
         end
         default: return; // drop unknown kinds, state untouched
      endcase
      frame_length = '0;
      scaled = '0;
      hsum = mcfb_pkg::FRAME_HEADER + opcode + motor_id + dlen;
      push_byte(mcfb_pkg::FRAME_HEADER, 1'b0);
      push_byte(opcode, 1'b0);
      push_byte(motor_id, 1'b0);
      push_byte(dlen, 1'b0);
      push_byte(hsum, dlen == mcfb_pkg::DLEN_NONE);
      last_checksum = hsum;
      if (dlen != mcfb_pkg::DLEN_NONE) begin
         scaled = value * mcfb_pkg::SCALE_FACTOR;
         ext = {8{scaled[31]}};
         dsum = '0;
         for (int i = 0; i < int'(dlen); i++) begin
            b = (i < 4) ? scaled[8*i +: 8] : ext;
            push_byte(b, 1'b0);
            dsum = dsum + b;
         end
         push_byte(dsum, 1'b1);
         last_checksum = dsum;
      end
      last_kind = kind;
      last_scaled = scaled;
   endfunction

   function void check_byte(logic [7:0] b, logic last);
      frame_entry_type e;
      if (pending_bytes.size() == 0) begin
         $error("unexpected frame byte %02h (last_byte %0b)", b, last);
         error_count++;
         return;
      end
      e = pending_bytes.pop_front();
      if (e.frame_byte !== b) begin
         $error("frame_byte: expected %02h, actual %02h", e.frame_byte, b);
         error_count++;
      end
      if (e.last_byte !== last) begin
         $error("last_byte: expected %0b, actual %0b", e.last_byte, last);
         error_count++;
      end
   endfunction
endclass

module tb_motor_command_frame_builder;

   localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
   localparam logic [2:0] KIND_BAD_MID   = 3'd6;
   localparam logic [2:0] KIND_BAD_LAST  = 3'd7;
   localparam int ITEMS_PER_PHASE = 78;
   localparam int PHASES          = 4;
   localparam int SETTLE_CYCLES   = 20;
   localparam int LONG_HOLD       = 250;
   localparam int IDLE_LIMIT      = 2000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_kind;
   logic signed [31:0] req_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [7:0]        rsp_frame_byte;
   logic              rsp_last_byte;
   logic              csr_write_enable;
   logic [7:0]        csr_write_data;

   frame_scoreboard sb = new();
   int burst_left;
   int max_gap;
   int hold_requests;
   int idle_cycles;

   motor_command_frame_builder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request, opening a new burst after a random gap when due.
   task automatic issue(input logic [2:0] kind, input logic [31:0] value);
      if (burst_left == 0) begin
         if (max_gap > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(max_gap, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(8, 1);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      sb.note_command(kind, value);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_motor_id(input logic [7:0] id);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= id;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_motor_id(id);
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7: v = $urandom;
         8, 9, 10, 11, 12: v = $urandom_range(200000) - 100000;
         13, 14, 15, 16: begin
            // straddle the points where value*100 crosses a sign or wrap boundary
            v = 32'd21474836 * $urandom_range(4, 1) + $urandom_range(4) - 2;
            if ($urandom_range(1)) v = -v;
         end
         default: begin
            case ($urandom_range(4))
               0: v = 32'h0000_0000;
               1: v = 32'h0000_0001;
               2: v = 32'hFFFF_FFFF;
               3: v = 32'h7FFF_FFFF;
               default: v = 32'h8000_0000;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [2:0] random_kind();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 3'($urandom_range(KIND_BAD_LAST, KIND_BAD_FIRST));
      if (r < 22) return 3'($urandom_range(mcfb_pkg::KIND_RESTORE, mcfb_pkg::KIND_OFF));
      if (r < 58) return mcfb_pkg::KIND_SPEED;
      return mcfb_pkg::KIND_ANGLE;
   endfunction

   // Receiver: stall on a pattern of its own, plus long hold-offs on request.
   initial begin
      stall_mode_type mode;
      int mode_left;
      int hold_left;
      int served;
      int tick;
      rsp_stall = 1'b0;
      mode = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      served = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_byte(rsp_frame_byte, rsp_last_byte);
         tick++;
         if (served != hold_requests) begin
            served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(3));
            mode_left = $urandom_range(256, 32);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(9) < 6);
               default:     rsp_stall <= ((tick % 5) < 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [7:0] phase_id;
      logic [2:0] kind;
      int count;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = '0;
      req_value = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      hold_requests = 0;
      burst_left = 0;
      max_gap = 3;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every kind, value extremes, overflow of the scaling, unknown kinds
      issue(mcfb_pkg::KIND_OFF, 32'h0000_0000);
      issue(mcfb_pkg::KIND_STOP, 32'hFFFF_FFFF);
      issue(mcfb_pkg::KIND_RESTORE, 32'h7FFF_FFFF);
      issue(mcfb_pkg::KIND_SPEED, 32'h0000_0000);
      issue(mcfb_pkg::KIND_SPEED, 32'h0000_0001);
      issue(mcfb_pkg::KIND_SPEED, 32'hFFFF_FFFF);
      issue(mcfb_pkg::KIND_SPEED, 32'h7FFF_FFFF);
      issue(mcfb_pkg::KIND_SPEED, 32'h8000_0000);
      issue(mcfb_pkg::KIND_SPEED, 32'd21474836);
      issue(mcfb_pkg::KIND_SPEED, 32'd21474837);
      issue(KIND_BAD_FIRST, 32'h1234_5678);
      issue(mcfb_pkg::KIND_ANGLE, 32'h0000_0000);
      issue(mcfb_pkg::KIND_ANGLE, 32'hFFFF_FFFF);
      issue(mcfb_pkg::KIND_ANGLE, 32'h8000_0000);
      issue(mcfb_pkg::KIND_ANGLE, 32'h7FFF_FFFF);
      issue(mcfb_pkg::KIND_ANGLE, 32'd21474837);
      issue(mcfb_pkg::KIND_ANGLE, -32'sd21474837);
      issue(KIND_BAD_MID, 32'hFFFF_FFFF);
      issue(KIND_BAD_LAST, 32'h0000_0000);
      issue(mcfb_pkg::KIND_ANGLE, 32'hAAAA_AAAA);
      issue(mcfb_pkg::KIND_SPEED, 32'h5555_5555);
      set_motor_id(8'hFF);
      issue(mcfb_pkg::KIND_OFF, 32'h0000_0000);
      issue(mcfb_pkg::KIND_ANGLE, 32'hFFFF_FFFF);
      set_motor_id(8'h00);
      issue(mcfb_pkg::KIND_STOP, 32'h0000_0000);
      issue(mcfb_pkg::KIND_SPEED, 32'd12345);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: phase_id = 8'($urandom_range(254, 2));
            1: phase_id = 8'hFF;
            2: phase_id = 8'($urandom);
            default: phase_id = 8'h00;
         endcase
         set_motor_id(phase_id);
         if (phase % 2 == 1) begin
            // hold the receiver off while requests keep coming back to back
            max_gap = 0;
            hold_requests <= hold_requests + 1;
         end else begin
            case ($urandom_range(2))
               0: max_gap = 4;
               1: max_gap = 12;
               default: max_gap = 30;
            endcase
         end
         count = 0;
         while (count < ITEMS_PER_PHASE) begin
            kind = random_kind();
            issue(kind, random_value());
            if (kind <= mcfb_pkg::KIND_ANGLE) count++;
         end
      end

      drain();
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
